// ===== hdl/hashed_key_latest_offset_table_macros.svh =====
// Assertion macros shared by the table design
`ifndef HASHED_KEY_LATEST_OFFSET_TABLE_MACROS_SVH
`define HASHED_KEY_LATEST_OFFSET_TABLE_MACROS_SVH

// Implication checked on every rising edge once out of reset
`define HKT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hkt_pkg.sv =====
`default_nettype none
package hkt_pkg;
    localparam int CAPACITY    = 256;
    localparam int OFFSET_BITS = 48;
    localparam int IDX_BITS    = $clog2(CAPACITY);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int CFG_BITS    = 9;

    // Cells between registered breaks in the chain
    localparam int CELLS_PER_SEG = 8;
    localparam int NUM_SEG       = (CAPACITY + CELLS_PER_SEG - 1) / CELLS_PER_SEG;

    localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] BASIS_FIRST  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] BASIS_SECOND = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RESET = CFG_BITS'(256);

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_LATEST = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_HASH   = 2'd1,
        ST_SEARCH = 2'd2,
        ST_DONE   = 2'd3
    } t_state;

    // Travels down the chain of cells during a search
    typedef struct packed {
        logic                   hit;
        logic [IDX_BITS-1:0]    hit_idx;
        logic [OFFSET_BITS-1:0] hit_ofs;
        logic                   free;
        logic [IDX_BITS-1:0]    free_idx;
    } t_scan;

    // Command from the controller to every cell
    typedef struct packed {
        logic                   clear;
        logic                   wr;
        logic [IDX_BITS-1:0]    wr_idx;
        logic                   wr_new;
        logic [63:0]            d1;
        logic [63:0]            d2;
        logic [OFFSET_BITS-1:0] ofs;
    } t_cell_cmd;
endpackage
`default_nettype wire

// ===== hdl/hkt_if.sv =====
`default_nettype none
interface hkt_in_if (input wire logic i_clk);
    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic [7:0]                     key_byte;
    logic                           key_last;
    logic [hkt_pkg::OFFSET_BITS-1:0] offset;
    modport source (output valid, cmd, key_byte, key_last, offset, input ready);
    modport sink   (input valid, cmd, key_byte, key_last, offset, output ready);
endinterface

interface hkt_out_if (input wire logic i_clk);
    logic                           valid;
    logic                           ready;
    logic                           put_accepted;
    logic                           found;
    logic [hkt_pkg::OFFSET_BITS-1:0] stored_offset;
    logic                           is_latest;
    modport source (output valid, put_accepted, found, stored_offset, is_latest, input ready);
    modport sink   (input valid, put_accepted, found, stored_offset, is_latest, output ready);
endinterface
`default_nettype wire

// ===== hdl/hkt_cell.sv =====
`default_nettype none
// One table entry; fold its match / free status into the passing scan record
module hkt_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [hkt_pkg::IDX_BITS-1:0] i_idx,
    input  wire hkt_pkg::t_cell_cmd      i_cmd,
    input  wire hkt_pkg::t_scan          i_scan,
    output hkt_pkg::t_scan               o_scan
);
    logic                            r_valid;
    logic [63:0]                     r_d1;
    logic [63:0]                     r_d2;
    logic [hkt_pkg::OFFSET_BITS-1:0] r_ofs;
    logic                            w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr && i_cmd.wr_idx == i_idx) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_cmd.wr_idx == i_idx) begin
            r_ofs <= i_cmd.ofs;
            if (i_cmd.wr_new) begin
                r_d1 <= i_cmd.d1;
                r_d2 <= i_cmd.d2;
            end
        end
    end

    assign w_match = r_valid && r_d1 == i_cmd.d1 && r_d2 == i_cmd.d2;

    always_comb begin
        o_scan = i_scan;
        if (w_match && !i_scan.hit) begin
            o_scan.hit     = 1'b1;
            o_scan.hit_idx = i_idx;
            o_scan.hit_ofs = r_ofs;
        end
        if (!r_valid && !i_scan.free) begin
            o_scan.free     = 1'b1;
            o_scan.free_idx = i_idx;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/hkt_chain.sv =====
`default_nettype none
// Row of cells; a registered break every eighth cell, with the scan record
// handed down the row from one break register to the next during a search
module hkt_chain (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hkt_pkg::t_cell_cmd i_cmd,
    input  wire logic               i_start,
    output hkt_pkg::t_scan          o_scan,
    output logic                    o_done
);
    hkt_pkg::t_scan w_link [hkt_pkg::CAPACITY+1];
    hkt_pkg::t_scan r_seg  [hkt_pkg::NUM_SEG];
    logic           r_vld  [hkt_pkg::NUM_SEG];
    hkt_pkg::t_scan w_seg_in [hkt_pkg::NUM_SEG];
    logic           w_vld_in [hkt_pkg::NUM_SEG];

    assign w_link[0] = '0;

    for (genvar s = 0; s < hkt_pkg::NUM_SEG; s++) begin : g_seg
        if (s == 0) begin : g_first
            assign w_seg_in[s] = '0;
            assign w_vld_in[s] = i_start;
        end else begin : g_rest
            assign w_seg_in[s] = r_seg[s-1];
            assign w_vld_in[s] = r_vld[s-1];
        end
        for (genvar c = s * hkt_pkg::CELLS_PER_SEG;
             c < (s + 1) * hkt_pkg::CELLS_PER_SEG && c < hkt_pkg::CAPACITY;
             c++) begin : g_c
            hkt_pkg::t_scan w_in;
            assign w_in = (c == s * hkt_pkg::CELLS_PER_SEG) ? w_seg_in[s] : w_link[c];
            hkt_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_idx  (hkt_pkg::IDX_BITS'(c)),
                .i_cmd  (i_cmd),
                .i_scan (w_in),
                .o_scan (w_link[c+1])
            );
        end
        always_ff @(posedge i_clk) begin
            r_seg[s] <= w_link[((s + 1) * hkt_pkg::CELLS_PER_SEG < hkt_pkg::CAPACITY) ?
                                (s + 1) * hkt_pkg::CELLS_PER_SEG : hkt_pkg::CAPACITY];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld_in[s];
            end
        end
    end

    assign o_scan = r_seg[hkt_pkg::NUM_SEG-1];
    assign o_done = r_vld[hkt_pkg::NUM_SEG-1];
endmodule
`default_nettype wire

// ===== hdl/hashed_key_latest_offset_table.sv =====
`default_nettype none
// Channel | Dir | Fields
// in      | in  | cmd, key_byte, key_last, offset
// out     | out | put_accepted, found, stored_offset, is_latest
// cfg     | in  | i_cfg_we / i_cfg_data -> max_entries
//
// A byte not marked last is accepted in idle, then folded into both hashes by the two
// 64-bit multiplies. A last byte adds a search through the chain of cells, started
// from a register once the digest is held, writing back as the search ends, and a
// done state holding the result; a clear skips the search.
// Reset is synchronous; it reloads the hash bases and clears the valid bits, count and control.
// The result waits in a register until taken; hold the next byte off until then.
module hashed_key_latest_offset_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [hkt_pkg::CFG_BITS-1:0]  i_cfg_data,
    hkt_in_if.sink                             in_if,
    hkt_out_if.source                          out_if
);
    hkt_pkg::t_state r_state, n_state;
    logic [hkt_pkg::CFG_BITS-1:0] r_max;
    logic [63:0] r_h1, r_h2, r_d1, r_d2;
    logic [7:0]  r_byte;
    logic        r_last;
    hkt_pkg::t_cmd r_cmd;
    logic [hkt_pkg::OFFSET_BITS-1:0] r_ofs;
    logic [hkt_pkg::CNT_BITS-1:0] r_count;
    logic        r_ovalid, r_acc, r_found, r_latest;
    logic [hkt_pkg::OFFSET_BITS-1:0] r_stored;
    logic        r_start;

    hkt_pkg::t_cell_cmd w_cmd;
    hkt_pkg::t_scan     w_scan;
    logic               w_done, w_start, w_take, w_finish;
    logic [63:0]        w_m1, w_m2;
    logic [hkt_pkg::CNT_BITS-1:0] w_limit;
    logic               w_ins;

    assign w_take = in_if.valid && in_if.ready;
    assign in_if.ready = (r_state == hkt_pkg::ST_IDLE);

    // Limit is the smaller of max_entries and capacity
    assign w_limit = (r_max > hkt_pkg::CFG_BITS'(hkt_pkg::CAPACITY)) ?
                     hkt_pkg::CNT_BITS'(hkt_pkg::CAPACITY) : hkt_pkg::CNT_BITS'(r_max);

    assign w_m1 = (r_h1 ^ {56'd0, r_byte}) * hkt_pkg::FNV_PRIME;
    assign w_m2 = (r_h2 ^ {56'd0, r_byte}) * hkt_pkg::FNV_PRIME;

    assign w_start  = (r_state == hkt_pkg::ST_HASH) && r_last && r_cmd != hkt_pkg::CMD_CLEAR;
    assign w_finish = (r_state == hkt_pkg::ST_SEARCH) && w_done;
    assign w_ins    = !w_scan.hit && w_scan.free && r_count < w_limit;

    always_comb begin
        w_cmd       = '0;
        w_cmd.d1    = r_d1;
        w_cmd.d2    = r_d2;
        w_cmd.clear = (r_state == hkt_pkg::ST_HASH) && r_last && r_cmd == hkt_pkg::CMD_CLEAR;
        if (w_finish && r_cmd == hkt_pkg::CMD_PUT) begin
            if (w_scan.hit) begin
                // Raise the stored offset only upward
                w_cmd.wr     = r_ofs > w_scan.hit_ofs;
                w_cmd.wr_idx = w_scan.hit_idx;
                w_cmd.ofs    = r_ofs;
            end else if (w_ins) begin
                w_cmd.wr     = 1'b1;
                w_cmd.wr_new = 1'b1;
                w_cmd.wr_idx = w_scan.free_idx;
                w_cmd.ofs    = r_ofs;
            end
        end
    end

    // Launch the scan once the digest registers hold the finished hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= w_start;
        end
    end

    hkt_chain u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_start(r_start),
        .o_scan (w_scan),
        .o_done (w_done)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            hkt_pkg::ST_IDLE:   if (w_take) n_state = hkt_pkg::ST_HASH;
            hkt_pkg::ST_HASH: begin
                if (!r_last) begin
                    n_state = hkt_pkg::ST_IDLE;
                end else if (r_cmd == hkt_pkg::CMD_CLEAR) begin
                    n_state = hkt_pkg::ST_DONE;
                end else begin
                    n_state = hkt_pkg::ST_SEARCH;
                end
            end
            hkt_pkg::ST_SEARCH: if (w_done) n_state = hkt_pkg::ST_DONE;
            hkt_pkg::ST_DONE:   if (!r_ovalid || out_if.ready) n_state = hkt_pkg::ST_IDLE;
            default:            n_state = hkt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= hkt_pkg::MAX_ENTRIES_RESET;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= in_if.key_byte;
            r_last <= in_if.key_last;
            r_cmd  <= hkt_pkg::t_cmd'(in_if.cmd);
            r_ofs  <= in_if.offset;
        end
    end

    // Fold the byte into both hashes; hold the digest, restart on last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1 <= hkt_pkg::BASIS_FIRST;
            r_h2 <= hkt_pkg::BASIS_SECOND;
        end else if (r_state == hkt_pkg::ST_HASH) begin
            if (r_last) begin
                r_h1 <= hkt_pkg::BASIS_FIRST;
                r_h2 <= hkt_pkg::BASIS_SECOND;
                r_d1 <= w_m1;
                r_d2 <= w_m2;
            end else begin
                r_h1 <= w_m1;
                r_h2 <= w_m2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cmd.clear) begin
            r_count <= '0;
        end else if (w_cmd.wr && w_cmd.wr_new) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Result register: present until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_finish || w_cmd.clear) begin
            r_ovalid <= 1'b1;
        end else if (out_if.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.clear) begin
            r_acc <= 1'b0; r_found <= 1'b0; r_stored <= '0; r_latest <= 1'b0;
        end else if (w_finish) begin
            r_found  <= w_scan.hit;
            r_acc    <= 1'b0;
            r_latest <= 1'b0;
            r_stored <= w_scan.hit ? w_scan.hit_ofs : '0;
            case (r_cmd)
                hkt_pkg::CMD_PUT: begin
                    r_acc <= w_scan.hit || w_ins;
                    if (w_scan.hit) begin
                        r_stored <= (r_ofs > w_scan.hit_ofs) ? r_ofs : w_scan.hit_ofs;
                    end else if (w_ins) begin
                        r_stored <= r_ofs;
                    end
                end
                hkt_pkg::CMD_LATEST: r_latest <= !w_scan.hit || r_ofs >= w_scan.hit_ofs;
                default: ;
            endcase
        end
    end

    assign out_if.valid         = r_ovalid;
    assign out_if.put_accepted  = r_acc;
    assign out_if.found         = r_found;
    assign out_if.stored_offset = r_stored;
    assign out_if.is_latest     = r_latest;

`include "hashed_key_latest_offset_table_macros.svh"
    `HKT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, in_if.ready, r_state == hkt_pkg::ST_IDLE, "ready outside idle")
    `HKT_ASSERT_IMP(a_count_lim, i_clk, i_rst_n, 1'b1, r_count <= hkt_pkg::CNT_BITS'(hkt_pkg::CAPACITY), "count beyond capacity")
    `HKT_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, w_finish, r_ovalid, "finished search gave no result")
endmodule
`default_nettype wire

// ===== tb/sv/hkt_tb_pkg.sv =====
`timescale 1ns / 100ps
package hkt_tb_pkg;
    import hkt_pkg::*;

    typedef struct {
        t_cmd                   cmd;
        logic [7:0]             key_byte;
        logic                   key_last;
        logic [OFFSET_BITS-1:0] offset;
    } t_key_byte_txn;

    typedef struct {
        logic                   put_accepted;
        logic                   found;
        logic [OFFSET_BITS-1:0] stored_offset;
        logic                   is_latest;
    } t_lookup_result;
endpackage

// ===== tb/sv/hashed_key_latest_offset_table_tb.sv =====
`timescale 1ns / 100ps
module hashed_key_latest_offset_table_tb;
    import hkt_pkg::*;
    import hkt_tb_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_data;

    hkt_in_if  in_ch  (.i_clk(clk));
    hkt_out_if out_ch (.i_clk(clk));

    hashed_key_latest_offset_table u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .in_if      (in_ch.sink),
        .out_if     (out_ch.source)
    );

    // Shadow of the block: running hashes, the table and the insert limit
    logic [63:0]            sh_hash_a;
    logic [63:0]            sh_hash_b;
    logic                   sh_valid [CAPACITY];
    logic [63:0]            sh_dig_a [CAPACITY];
    logic [63:0]            sh_dig_b [CAPACITY];
    logic [OFFSET_BITS-1:0] sh_ofs   [CAPACITY];
    int                     sh_count;
    int                     sh_limit;

    t_key_byte_txn  pending_bytes[$];
    t_lookup_result expected_lookups[$];

    int     fail_count;
    longint cycle_count;
    bit     stimulus_done;
    bit     long_hold;   // receiver held off while the sender keeps offering
    int     send_gap;
    int     take_gap;

    // Small pool of keys so that puts, gets and updates hit the same digests
    byte unsigned key_pool [16][4];
    int           key_len  [16];

    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hashed_key_latest_offset_table_tb: FAIL");
            $finish;
        end
    end

    task automatic shadow_clear();
        for (int i = 0; i < CAPACITY; i++) sh_valid[i] = 1'b0;
        sh_count = 0;
    endtask

    // Fold one byte into both hashes; on the last byte run the command
    // against the shadow table and queue the expected result.
    task automatic predict_lookup(input t_key_byte_txn t);
        t_lookup_result r;
        int             slot;
        int             free_slot;
        logic [63:0]    d_a;
        logic [63:0]    d_b;
        sh_hash_a = (sh_hash_a ^ {56'd0, t.key_byte}) * FNV_PRIME;
        sh_hash_b = (sh_hash_b ^ {56'd0, t.key_byte}) * FNV_PRIME;
        if (!t.key_last) return;
        d_a = sh_hash_a;
        d_b = sh_hash_b;
        sh_hash_a = BASIS_FIRST;
        sh_hash_b = BASIS_SECOND;
        r = '{1'b0, 1'b0, '0, 1'b0};
        if (t.cmd == CMD_CLEAR) begin
            shadow_clear();
        end else begin
            slot = -1;
            for (int i = 0; i < CAPACITY; i++)
                if (slot < 0 && sh_valid[i] && sh_dig_a[i] == d_a && sh_dig_b[i] == d_b)
                    slot = i;
            if (slot >= 0) begin
                r.found = 1'b1;
                r.stored_offset = sh_ofs[slot];
            end
            if (t.cmd == CMD_PUT) begin
                if (r.found) begin
                    if (t.offset > sh_ofs[slot]) sh_ofs[slot] = t.offset;
                    r.stored_offset = sh_ofs[slot];
                    r.put_accepted = 1'b1;
                end else if (sh_count < sh_limit) begin
                    free_slot = -1;
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (!sh_valid[i]) free_slot = i;
                    if (free_slot >= 0) begin
                        sh_valid[free_slot] = 1'b1;
                        sh_dig_a[free_slot] = d_a;
                        sh_dig_b[free_slot] = d_b;
                        sh_ofs[free_slot]   = t.offset;
                        sh_count++;
                        r.stored_offset = t.offset;
                        r.put_accepted  = 1'b1;
                    end
                end
            end else if (t.cmd == CMD_LATEST) begin
                r.is_latest = !r.found || t.offset >= r.stored_offset;
            end
        end
        expected_lookups.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] rand_offset();
        logic [OFFSET_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = OFFSET_BITS'($urandom_range(0, 15));
            default: v = OFFSET_BITS'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    task automatic queue_key(input int k, input t_cmd c, input logic [OFFSET_BITS-1:0] o);
        t_key_byte_txn t;
        for (int i = 0; i < key_len[k]; i++) begin
            t.key_byte = key_pool[k][i];
            t.key_last = (i == key_len[k] - 1);
            // cmd and offset on earlier bytes are noise that must be ignored
            t.cmd      = t.key_last ? c : t_cmd'($urandom_range(0, 3));
            t.offset   = t.key_last ? o : rand_offset();
            pending_bytes.push_back(t);
        end
    endtask

    task automatic queue_raw(input t_cmd c, input logic [7:0] b, input logic [OFFSET_BITS-1:0] o);
        t_key_byte_txn t;
        t.cmd = c;
        t.key_byte = b;
        t.key_last = 1'b1;
        t.offset = o;
        pending_bytes.push_back(t);
    endtask

    // Drain the input queue and the results, then let the block settle
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || expected_lookups.size() != 0) @(posedge clk);
        repeat (CAPACITY / 8 + 10) @(posedge clk);
    endtask

    task automatic write_limit(input int value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= CFG_BITS'(value);
        sh_limit = (value < CAPACITY) ? value : CAPACITY;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Driver: present the head of the queue, predict on acceptance, and
    // drop valid for a random gap between transactions.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_lookup(pending_bytes.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered transaction
            end else if (send_gap > 0) begin
                send_gap    <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                in_ch.valid    <= 1'b1;
                in_ch.cmd      <= pending_bytes[0].cmd;
                in_ch.key_byte <= pending_bytes[0].key_byte;
                in_ch.key_last <= pending_bytes[0].key_last;
                in_ch.offset   <= pending_bytes[0].offset;
                send_gap       <= pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: take a result, compare it field by field with the oldest
    // expectation, and stall ready at random.
    always @(posedge clk) begin
        t_lookup_result want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            take_gap     <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_lookups.size() == 0) begin
                    $display("[%0t] result with nothing expected", $realtime);
                    fail_count++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (out_ch.put_accepted !== want.put_accepted)
                        report_mismatch("put_accepted", out_ch.put_accepted, want.put_accepted);
                    if (out_ch.found !== want.found)
                        report_mismatch("found", out_ch.found, want.found);
                    if (out_ch.stored_offset !== want.stored_offset)
                        report_mismatch("stored_offset", out_ch.stored_offset,
                                        want.stored_offset);
                    if (out_ch.is_latest !== want.is_latest)
                        report_mismatch("is_latest", out_ch.is_latest, want.is_latest);
                end
            end
            if (long_hold) begin
                out_ch.ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap     <= take_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                take_gap     <= pick_gap();
            end
        end
    end

    initial begin
        int k;
        int n;
        int limits[4];
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.cmd    = CMD_PUT;
        in_ch.key_byte = '0;
        in_ch.key_last = 1'b0;
        in_ch.offset = '0;
        out_ch.ready = 1'b0;
        fail_count   = 0;
        long_hold    = 1'b0;
        stimulus_done = 1'b0;
        sh_hash_a    = BASIS_FIRST;
        sh_hash_b    = BASIS_SECOND;
        sh_limit     = CAPACITY;
        shadow_clear();
        for (int i = 0; i < 16; i++) begin
            key_len[i] = $urandom_range(1, 4);
            for (int j = 0; j < 4; j++) key_pool[i][j] = byte'($urandom);
        end
        key_pool[0][0] = 8'h00;
        key_pool[1][0] = 8'hFF;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every command, offset extremes, equal offsets, absent keys
        queue_key(0, CMD_GET, '1);
        queue_key(0, CMD_LATEST, '0);
        queue_key(0, CMD_PUT, 48'd100);
        queue_key(0, CMD_PUT, 48'd50);
        queue_key(0, CMD_LATEST, 48'd100);
        queue_key(0, CMD_LATEST, 48'd99);
        queue_key(1, CMD_PUT, '1);
        queue_key(1, CMD_GET, '0);
        queue_key(1, CMD_LATEST, '1);
        queue_raw(CMD_GET, 8'hFF, '0);
        queue_key(2, CMD_CLEAR, '1);
        queue_key(0, CMD_GET, '0);
        wait_idle();

        // Zero limit: new keys refused, then full table still updates matches
        write_limit(0);
        queue_key(3, CMD_PUT, 48'd7);
        queue_key(3, CMD_GET, 48'd7);
        wait_idle();
        write_limit(1);
        queue_key(3, CMD_PUT, 48'd7);
        queue_key(4, CMD_PUT, 48'd8);
        queue_key(3, CMD_PUT, 48'd9);
        queue_key(3, CMD_LATEST, 48'd8);
        wait_idle();

        // Long receiver hold so the block backs up into the input
        long_hold = 1'b1;
        for (int i = 0; i < 12; i++) queue_key(i, CMD_PUT, rand_offset());
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
        wait_idle();

        // Random phases over several limits, the maximum among them
        limits[0] = 511;
        limits[1] = 5;
        limits[2] = 256;
        limits[3] = 12;
        for (int p = 0; p < 4; p++) begin
            write_limit(limits[p]);
            n = 0;
            while (n < 150) begin
                k = $urandom_range(0, 99);
                if (k < 3) begin
                    queue_key($urandom_range(0, 15), CMD_CLEAR, rand_offset());
                    n += 2;
                end else if (k < 15) begin
                    // fresh random key: insert pressure toward the limit
                    for (int j = 0; j < 4; j++) key_pool[15][j] = byte'($urandom);
                    key_len[15] = $urandom_range(1, 4);
                    queue_key(15, CMD_PUT, rand_offset());
                    n += 3;
                end else begin
                    queue_key($urandom_range(0, 14), t_cmd'($urandom_range(0, 2)),
                              rand_offset());
                    n += 3;
                end
            end
            wait_idle();
        end
        stimulus_done = 1'b1;

        if (fail_count == 0 && expected_lookups.size() == 0) begin
            $display("hashed_key_latest_offset_table_tb: PASS");
        end else begin
            $display("hashed_key_latest_offset_table_tb: FAIL");
        end
        $finish;
    end
endmodule
